// ----- hw/rtl/swr_pkg.sv -----
// types and constants shared by the sliding window receiver modules
package swr_pkg;

   // window geometry
   localparam int unsigned WINDOW     = 32;
   localparam int unsigned SLOT_W     = 5;     // log2 of WINDOW
   localparam int unsigned SEG_BYTES  = 1024;
   localparam int unsigned SEG_SHIFT  = 10;    // log2 of SEG_BYTES
   localparam int unsigned LEN_W      = 11;
   localparam int unsigned OFFSET_W   = 15;
   localparam int unsigned BYTES_W    = 16;
   localparam int unsigned FREE_W     = 6;

   // configuration port
   localparam int unsigned ADDR_W     = 3;
   localparam logic        CSR_LOCAL_PORT = 1'b0;   // register index, paddr[2]

   typedef enum logic [2:0] {
      KIND_STORED    = 3'd0,
      KIND_DUPLICATE = 3'd1,
      KIND_DROPPED   = 3'd2,
      KIND_DROP_FLUSH = 3'd3,
      KIND_FIN_ACK   = 3'd4,
      KIND_CLOSED    = 3'd5
   } kind_type;

   // header as held in the queue, payload length already clamped
   typedef struct packed {
      logic [31:0]      seq_num;
      logic             fin_flag;
      logic [LEN_W-1:0] store_len;
      logic [15:0]      sender_port;
   } hdr_type;

   typedef struct packed {
      kind_type            result_kind;
      logic [31:0]         ack_seq;
      logic [15:0]         ack_src_port;
      logic [15:0]         ack_dest_port;
      logic                fin_ack;
      logic [OFFSET_W-1:0] slot_offset;
      logic [LEN_W-1:0]    store_len;
      logic [BYTES_W-1:0]  flush_bytes;
   } rsp_type;

endpackage

// ----- hw/rtl/swr_front.sv -----
// front end: header intake, length clamp and two-entry queue
module swr_front import swr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [31:0]      req_seq_num,
   input  logic             req_fin_flag,
   input  logic [LEN_W-1:0] req_payload_len,
   input  logic [15:0]      req_sender_port,
   output logic             q_valid,
   output hdr_type          q_hdr,
   input  logic             q_pop
);

   hdr_type    hdr_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   hdr_type    hdr_new;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_hdr     = hdr_ff[rd_ptr_ff];

   always_comb begin
      hdr_new.seq_num     = req_seq_num;
      hdr_new.fin_flag    = req_fin_flag;
      hdr_new.sender_port = req_sender_port;
      // oversize payloads are stored as one full segment
      if (req_payload_len > LEN_W'(SEG_BYTES)) begin
         hdr_new.store_len = LEN_W'(SEG_BYTES);
      end else begin
         hdr_new.store_len = req_payload_len;
      end
   end

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         hdr_ff[wr_ptr_ff] <= hdr_new;
      end
   end

endmodule

// ----- hw/rtl/swr_back.sv -----
// back end: window state update and registered result beat
module swr_back import swr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  hdr_type     q_hdr,
   output logic        q_pop,
   input  logic [15:0] local_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp
);

   logic [WINDOW-1:0]  map_ff, map_in;
   logic [31:0]        base_ff, base_in;
   logic [FREE_W-1:0]  free_ff, free_in;
   logic [BYTES_W-1:0] buf_ff, buf_in;
   logic [31:0]        last_seq_ff, last_seq_in;
   logic [15:0]        last_dest_ff, last_dest_in;
   logic               closed_ff, closed_in;
   logic               ack_valid_ff, ack_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [31:0]        seq_delta;
   logic               in_window;
   logic [SLOT_W-1:0]  idx;
   logic [BYTES_W:0]   buf_sum;

   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // modulo 2^32 distance from the window base
   assign seq_delta = q_hdr.seq_num - base_ff;
   assign in_window = (seq_delta[31:SLOT_W] == '0);
   assign idx       = seq_delta[SLOT_W-1:0];
   assign buf_sum   = {1'b0, buf_ff} + (BYTES_W+1)'(q_hdr.store_len);

   always_comb begin
      map_in       = map_ff;
      base_in      = base_ff;
      free_in      = free_ff;
      buf_in       = buf_ff;
      last_seq_in  = last_seq_ff;
      last_dest_in = last_dest_ff;
      closed_in    = closed_ff;
      ack_valid_in = ack_valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (closed_ff) begin
            rsp_in.result_kind = KIND_CLOSED;
         end else if (q_hdr.fin_flag) begin
            rsp_in.result_kind   = KIND_FIN_ACK;
            rsp_in.ack_seq       = last_seq_ff;
            rsp_in.ack_src_port  = ack_valid_ff ? local_port : 16'd0;
            rsp_in.ack_dest_port = last_dest_ff;
            rsp_in.fin_ack       = 1'b1;
            rsp_in.flush_bytes   = buf_ff;
            closed_in            = 1'b1;
         end else if (in_window) begin
            rsp_in.ack_seq       = q_hdr.seq_num;
            rsp_in.ack_src_port  = local_port;
            rsp_in.ack_dest_port = q_hdr.sender_port;
            last_seq_in          = q_hdr.seq_num;
            last_dest_in         = q_hdr.sender_port;
            ack_valid_in         = 1'b1;
            if (!map_ff[idx]) begin
               rsp_in.result_kind = KIND_STORED;
               rsp_in.slot_offset = OFFSET_W'({idx, {SEG_SHIFT{1'b0}}});
               rsp_in.store_len   = q_hdr.store_len;
               map_in[idx]        = 1'b1;
               if (free_ff != '0) begin
                  free_in = free_ff - FREE_W'(1);
               end
               // byte count saturates
               if (buf_sum[BYTES_W]) begin
                  buf_in = '1;
               end else begin
                  buf_in = buf_sum[BYTES_W-1:0];
               end
            end else begin
               rsp_in.result_kind = KIND_DUPLICATE;
            end
         end else if (free_ff == '0) begin
            // full window and a packet beyond it: flush and slide
            rsp_in.result_kind = KIND_DROP_FLUSH;
            rsp_in.flush_bytes = buf_ff;
            base_in            = base_ff + 32'(WINDOW);
            map_in             = '0;
            free_in            = FREE_W'(WINDOW);
            buf_in             = '0;
         end else begin
            rsp_in.result_kind = KIND_DROPPED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= '0;
         base_ff      <= '0;
         free_ff      <= FREE_W'(WINDOW);
         buf_ff       <= '0;
         last_seq_ff  <= '0;
         last_dest_ff <= '0;
         closed_ff    <= 1'b0;
         ack_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff       <= map_in;
         base_ff      <= base_in;
         free_ff      <= free_in;
         buf_ff       <= buf_in;
         last_seq_ff  <= last_seq_in;
         last_dest_ff <= last_dest_in;
         closed_ff    <= closed_in;
         ack_valid_ff <= ack_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ----- hw/rtl/sliding_window_receiver.sv -----
// top level of the sliding window receiver: csr, front end and back end
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   seq_num, fin_flag, payload_len, sender_port
//   rsp      out        rsp_valid/rsp_stall   result_kind, ack fields, slot, store, flush
//   csr      in/out     psel/penable/pready   local_port at byte address 0
//
// one header per cycle sustained while rsp_stall is low; the window update in the back end
// is combinational into the result register, so a beat leaves through that register
// once it is popped from the head of the queue
// reset is synchronous and clears the window, counters and queue at once
// rsp_stall holds the result register; the two-entry queue keeps taking req
// beats until it is full, then req_stall rises
module sliding_window_receiver import swr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // header channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [31:0]         req_seq_num,
   input  logic                req_fin_flag,
   input  logic [LEN_W-1:0]    req_payload_len,
   input  logic [15:0]         req_sender_port,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_result_kind,
   output logic [31:0]         rsp_ack_seq,
   output logic [15:0]         rsp_ack_src_port,
   output logic [15:0]         rsp_ack_dest_port,
   output logic                rsp_fin_ack,
   output logic [OFFSET_W-1:0] rsp_slot_offset,
   output logic [LEN_W-1:0]    rsp_store_len,
   output logic [BYTES_W-1:0]  rsp_flush_bytes,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [15:0] local_port_ff, local_port_in;
   logic        csr_write;
   logic        q_valid;
   logic        q_pop;
   hdr_type     q_hdr;
   rsp_type     rsp;

   // csr: single register, word index taken from paddr[2]
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      local_port_in = local_port_ff;
      if (csr_write && (paddr[2] == CSR_LOCAL_PORT)) begin
         local_port_in = pwdata[15:0];
      end
   end

   always_comb begin
      if (paddr[2] == CSR_LOCAL_PORT) begin
         prdata = {16'd0, local_port_ff};
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_port_ff <= '0;
      end else begin
         local_port_ff <= local_port_in;
      end
   end

   // intake and queue
   swr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_seq_num     (req_seq_num),
      .req_fin_flag    (req_fin_flag),
      .req_payload_len (req_payload_len),
      .req_sender_port (req_sender_port),
      .q_valid         (q_valid),
      .q_hdr           (q_hdr),
      .q_pop           (q_pop)
   );

   // window state and result register
   swr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_hdr      (q_hdr),
      .q_pop      (q_pop),
      .local_port (local_port_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // result beat fields
   assign rsp_result_kind   = rsp.result_kind;
   assign rsp_ack_seq       = rsp.ack_seq;
   assign rsp_ack_src_port  = rsp.ack_src_port;
   assign rsp_ack_dest_port = rsp.ack_dest_port;
   assign rsp_fin_ack       = rsp.fin_ack;
   assign rsp_slot_offset   = rsp.slot_offset;
   assign rsp_store_len     = rsp.store_len;
   assign rsp_flush_bytes   = rsp.flush_bytes;

endmodule
